### hw/rtl/sos_pkg.sv
// Shared types, constants and step tables of the biquad cascade bank.
`timescale 1ns / 1ps

package sos_pkg;

  localparam int DATA_W    = 16;
  localparam int COEF_W    = 16;
  localparam int HIST_W    = 32;
  localparam int PROD_W    = COEF_W + HIST_W;
  localparam int NUM_SLOTS = 6;
  localparam int CFG_BANKS = 3;
  localparam int STEPS     = 6;
  localparam int CYC_W     = 4;
  localparam int LAST_CYC  = 8;

  localparam logic [2:0] SLOT_B0   = 3'd0;
  localparam logic [2:0] SLOT_B1   = 3'd1;
  localparam logic [2:0] SLOT_B2   = 3'd2;
  localparam logic [2:0] SLOT_A1   = 3'd3;
  localparam logic [2:0] SLOT_A2   = 3'd4;
  localparam logic [2:0] SLOT_GAIN = 3'd5;

  localparam logic [1:0] REG_BAND_ENABLE   = 2'd0;
  localparam logic [1:0] REG_SECTIONS_LOW  = 2'd1;
  localparam logic [1:0] REG_SECTIONS_BP   = 2'd2;
  localparam logic [1:0] REG_SECTIONS_HIGH = 2'd3;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    OP_X,
    OP_W1,
    OP_W2,
    OP_W0
  } opsel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_A_LOAD,
    ACC_A_SUB,
    ACC_B_LOAD,
    ACC_B_ADD
  } accop_e;

  typedef struct packed {
    logic   mul_en;
    opsel_e opsel;
    accop_e acc_op;
  } mac_ctrl_t;

  // step order: gain, a1, a2, b1, b2, b0
  function automatic logic [2:0] step_slot(input logic [2:0] step);
    logic [2:0] slot;
    case (step)
      3'd0:    slot = SLOT_GAIN;
      3'd1:    slot = SLOT_A1;
      3'd2:    slot = SLOT_A2;
      3'd3:    slot = SLOT_B1;
      3'd4:    slot = SLOT_B2;
      3'd5:    slot = SLOT_B0;
      default: slot = SLOT_B0;
    endcase
    return slot;
  endfunction

  function automatic opsel_e step_opsel(input logic [2:0] step);
    opsel_e op;
    case (step)
      3'd0:    op = OP_X;
      3'd1:    op = OP_W1;
      3'd2:    op = OP_W2;
      3'd3:    op = OP_W1;
      3'd4:    op = OP_W2;
      3'd5:    op = OP_W0;
      default: op = OP_X;
    endcase
    return op;
  endfunction

  function automatic accop_e step_accop(input logic [2:0] step);
    accop_e op;
    case (step)
      3'd0:    op = ACC_A_LOAD;
      3'd1:    op = ACC_A_SUB;
      3'd2:    op = ACC_A_SUB;
      3'd3:    op = ACC_B_LOAD;
      3'd4:    op = ACC_B_ADD;
      3'd5:    op = ACC_B_ADD;
      default: op = ACC_NONE;
    endcase
    return op;
  endfunction

endpackage

### hw/rtl/sos_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sos_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 144,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sos_mac.sv
// Shared multiplier with the two section accumulators and output saturation.
`timescale 1ns / 1ps

module sos_mac #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                  clk_i,
  input  sos_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [sos_pkg::COEF_W-1:0]     coef_i,
  input  logic signed [sos_pkg::DATA_W-1:0]     x_i,
  input  logic signed [sos_pkg::HIST_W-1:0]     w1_i,
  input  logic signed [sos_pkg::HIST_W-1:0]     w2_i,
  output logic signed [sos_pkg::HIST_W-1:0]     w0_o,
  output logic signed [sos_pkg::DATA_W-1:0]     ys_o
);
  import sos_pkg::*;

  logic signed [HIST_W-1:0] operand;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [HIST_W-1:0] term;
  logic signed [HIST_W-1:0] acc_a_q, acc_b_q;

  always_comb begin
    case (ctrl_i.opsel)
      OP_X:    operand = HIST_W'(x_i);
      OP_W1:   operand = w1_i;
      OP_W2:   operand = w2_i;
      OP_W0:   operand = acc_a_q;
      default: operand = '0;
    endcase
  end

  assign prod_d  = PROD_W'(coef_i) * PROD_W'(operand);
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign term    = prod_sh[HIST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    case (ctrl_i.acc_op)
      ACC_A_LOAD: acc_a_q <= term;
      ACC_A_SUB:  acc_a_q <= acc_a_q - term;
      ACC_B_LOAD: acc_b_q <= term;
      ACC_B_ADD:  acc_b_q <= acc_b_q + term;
      default:    ;
    endcase
  end

  always_comb begin
    if (acc_b_q > HIST_W'(SAT_MAX)) begin
      ys_o = SAT_MAX;
    end else if (acc_b_q < HIST_W'(SAT_MIN)) begin
      ys_o = SAT_MIN;
    end else begin
      ys_o = acc_b_q[DATA_W-1:0];
    end
  end

  assign w0_o = acc_a_q;

endmodule

### hw/rtl/sos_iir_filter_bank_q14_unit.sv
// Top level: sequencer, coefficient and history RAMs, configuration and stream ports.
//
//   channel  | dir | transfer condition              | content
//   s_axis   | in  | s_axis_tvalid & s_axis_tready   | sample or coefficient write item
//   m_axis   | out | m_axis_tvalid & m_axis_tready   | filtered sample
//   cfg      | in  | cfg_we_i                        | band enable and section counts
//
// A coefficient write goes to the coefficient RAM as it is taken, if its address is in range.
// A filter sample visits ST_BANK for each of BANKS_RUN = min(NUM_BANKS, 3) banks, runs the sections
// of each enabled bank in ST_RUN on the one shared multiplier, then ends in ST_DONE.
// Reset clears the sequencer and the history valid bits and sets the configuration to its defaults; no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module sos_iir_filter_bank_q14_unit #(
  parameter int MAX_SECTIONS = 8,
  parameter int FRAC_BITS    = 14,
  parameter int NUM_BANKS    = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample[15:0], coef_bank[17:16], coef_section[20:18], coef_slot[23:21],
  // coef_value[39:24]
  input  logic [39:0] s_axis_tdata,
  // func[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // filtered[15:0]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i
);
  import sos_pkg::*;

  localparam int BANKS_RUN = (NUM_BANKS < CFG_BANKS) ? NUM_BANKS : CFG_BANKS;
  localparam int BANK_W    = $clog2(BANKS_RUN + 1);
  localparam int HIST_D    = NUM_BANKS * MAX_SECTIONS;
  localparam int HIST_AW   = (HIST_D > 1) ? $clog2(HIST_D) : 1;
  localparam int COEF_D    = HIST_D * NUM_SLOTS;
  localparam int COEF_AW   = $clog2(COEF_D);
  localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SECN_W    = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BANK = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                     in_func;
  logic signed [DATA_W-1:0] in_sample;
  logic [1:0]               in_bank;
  logic [2:0]               in_section;
  logic [2:0]               in_slot;
  logic [COEF_W-1:0]        in_value;

  logic [2:0] band_enable_q;
  logic [3:0] sec_low_q, sec_bp_q, sec_high_q;

  logic [BANK_W-1:0]        bank_q, bank_d;
  logic [SEC_W-1:0]         sec_q, sec_d;
  logic [CYC_W-1:0]         cyc_q, cyc_d;
  logic signed [DATA_W-1:0] sample_q, sample_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic [DATA_W-1:0]        sum_q, sum_d;
  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        out_q, out_d;
  logic [HIST_D-1:0]        hv_q, hv_d;
  logic                     hv_rd_q, hv_rd_d;

  logic                     in_xfer;
  logic                     coef_ok;
  logic                     coef_we;
  logic [COEF_AW-1:0]       coef_waddr, coef_raddr;
  logic                     coef_re;
  logic signed [COEF_W-1:0] coef_rdata;
  logic [3:0]               cnt_sel;
  logic [SECN_W-1:0]        n_eff;
  logic                     bank_en;
  logic                     last_sec;
  logic                     run;
  logic [CYC_W-1:0]         mstep, astep;
  logic [HIST_AW-1:0]       hist_addr;
  logic                     hist_re, hist_we;
  logic [2*HIST_W-1:0]      hist_rdata;
  logic signed [HIST_W-1:0] w1, w2, w0;
  logic signed [DATA_W-1:0] ys;
  mac_ctrl_t                ctrl;

  assign in_func    = s_axis_tuser[0];
  assign in_sample  = s_axis_tdata[15:0];
  assign in_bank    = s_axis_tdata[17:16];
  assign in_section = s_axis_tdata[20:18];
  assign in_slot    = s_axis_tdata[23:21];
  assign in_value   = s_axis_tdata[39:24];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_enable_q <= 3'd0;
      sec_low_q     <= 4'd7;
      sec_bp_q      <= 4'd8;
      sec_high_q    <= 4'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BAND_ENABLE:   band_enable_q <= cfg_wdata_i[2:0];
        REG_SECTIONS_LOW:  sec_low_q     <= cfg_wdata_i;
        REG_SECTIONS_BP:   sec_bp_q      <= cfg_wdata_i;
        REG_SECTIONS_HIGH: sec_high_q    <= cfg_wdata_i;
        default:           ;
      endcase
    end
  end

  // coefficient store
  assign coef_ok = (int'(in_bank) < NUM_BANKS) && (int'(in_section) < MAX_SECTIONS)
                && (int'(in_slot) < NUM_SLOTS);
  assign coef_we    = in_xfer && in_func && coef_ok;
  assign coef_waddr = COEF_AW'((int'(in_bank) * MAX_SECTIONS + int'(in_section)) * NUM_SLOTS
                               + int'(in_slot));
  assign run        = (state_q == ST_RUN);
  assign coef_re    = run && (cyc_q < CYC_W'(STEPS));
  assign coef_raddr = COEF_AW'((int'(bank_q) * MAX_SECTIONS + int'(sec_q)) * NUM_SLOTS
                               + int'(step_slot(cyc_q[2:0])));

  sos_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_D)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_value),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // history store: low word w1, high word w2
  assign hist_addr = HIST_AW'(int'(bank_q) * MAX_SECTIONS + int'(sec_q));
  assign hist_re   = run && (cyc_q == '0);
  assign hist_we   = run && (cyc_q == CYC_W'(LAST_CYC));
  assign w1        = hv_rd_q ? hist_rdata[HIST_W-1:0] : '0;
  assign w2        = hv_rd_q ? hist_rdata[2*HIST_W-1:HIST_W] : '0;

  sos_ram #(
    .WIDTH (2 * HIST_W),
    .DEPTH (HIST_D)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_addr),
    .wdata_i ({w1, w0}),
    .re_i    (hist_re),
    .raddr_i (hist_addr),
    .rdata_o (hist_rdata)
  );

  // shared multiplier schedule: read the coefficient, multiply it, then accumulate the registered product
  assign mstep = cyc_q - CYC_W'(1);
  assign astep = cyc_q - CYC_W'(2);

  always_comb begin
    ctrl.mul_en = run && (cyc_q >= CYC_W'(1)) && (cyc_q <= CYC_W'(STEPS));
    ctrl.opsel  = step_opsel(mstep[2:0]);
    if (run && (cyc_q >= CYC_W'(2)) && (cyc_q <= CYC_W'(STEPS + 1))) begin
      ctrl.acc_op = step_accop(astep[2:0]);
    end else begin
      ctrl.acc_op = ACC_NONE;
    end
  end

  sos_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .coef_i (coef_rdata),
    .x_i    (x_q),
    .w1_i   (w1),
    .w2_i   (w2),
    .w0_o   (w0),
    .ys_o   (ys)
  );

  // bank selection
  always_comb begin
    if (bank_q == BANK_W'(0)) begin
      cnt_sel = sec_low_q;
    end else if (bank_q == BANK_W'(1)) begin
      cnt_sel = sec_bp_q;
    end else begin
      cnt_sel = sec_high_q;
    end
  end

  assign n_eff    = (int'(cnt_sel) > MAX_SECTIONS) ? SECN_W'(MAX_SECTIONS) : SECN_W'(cnt_sel);
  assign bank_en  = |(band_enable_q & (3'b001 << bank_q));
  assign last_sec = ((SECN_W + 1)'(sec_q) + (SECN_W + 1)'(1)) == (SECN_W + 1)'(n_eff);

  // sequencer
  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    sec_d       = sec_q;
    cyc_d       = cyc_q;
    sample_d    = sample_q;
    x_d         = x_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    hv_d        = hv_q;
    hv_rd_d     = hv_rd_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer && !in_func) begin
          sample_d = in_sample;
          sum_d    = '0;
          bank_d   = '0;
          state_d  = ST_BANK;
        end
      end
      ST_BANK: begin
        if (bank_q == BANK_W'(BANKS_RUN)) begin
          state_d = ST_DONE;
        end else if (bank_en && (n_eff != '0)) begin
          sec_d   = '0;
          cyc_d   = '0;
          x_d     = sample_q;
          state_d = ST_RUN;
        end else begin
          bank_d = bank_q + BANK_W'(1);
        end
      end
      ST_RUN: begin
        if (hist_re) begin
          hv_rd_d = hv_q[hist_addr];
        end
        if (hist_we) begin
          hv_d[hist_addr] = 1'b1;
          if (last_sec) begin
            sum_d   = sum_q + DATA_W'(ys);
            bank_d  = bank_q + BANK_W'(1);
            state_d = ST_BANK;
          end else begin
            sec_d = sec_q + SEC_W'(1);
            x_d   = ys;
            cyc_d = '0;
          end
        end else begin
          cyc_d = cyc_q + CYC_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = sum_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= '0;
      sec_q       <= '0;
      cyc_q       <= '0;
      out_valid_q <= 1'b0;
      hv_q        <= '0;
      hv_rd_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      sec_q       <= sec_d;
      cyc_q       <= cyc_d;
      out_valid_q <= out_valid_d;
      hv_q        <= hv_d;
      hv_rd_q     <= hv_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    x_q      <= x_d;
    sum_q    <= sum_d;
    out_q    <= out_d;
  end

  a_sec_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((SECN_W + 1)'(sec_q) < (SECN_W + 1)'(n_eff)))
    else $error("section index beyond bank section count");

  a_cyc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cyc_q <= CYC_W'(LAST_CYC)))
    else $error("section cycle counter overran");

  a_section_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cyc_q == CYC_W'(LAST_CYC))
      |=> (state_q == ST_BANK || (state_q == ST_RUN && cyc_q == '0)))
    else $error("section end did not advance the sequencer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  a_bank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BANK) |-> (int'(bank_q) <= BANKS_RUN))
    else $error("bank counter overran");

endmodule

### bench/sos_filter_checker.sv
// Bench package and scoreboard that predicts and checks the filter bank output transfers.
`timescale 1ns / 1ps

package sos_bench_pkg;

  typedef enum logic [0:0] {
    FUNC_FILTER = 1'b0,
    FUNC_COEF   = 1'b1
  } func_e;

  localparam logic [1:0] BANK_LOW  = 2'd0;
  localparam logic [1:0] BANK_BP   = 2'd1;
  localparam logic [1:0] BANK_HIGH = 2'd2;
  localparam logic [1:0] BANK_NONE = 2'd3;

  // lowest bits first: pcm, coef_bank, coef_section, coef_slot, coef_value
  typedef struct packed {
    logic [15:0] coef_value;
    logic [2:0]  coef_slot;
    logic [2:0]  coef_section;
    logic [1:0]  coef_bank;
    logic [15:0] pcm;
  } item_t;

endpackage

module sos_filter_checker #(
  parameter int MAX_SECTIONS = 8,
  parameter int FRAC_BITS    = 14,
  parameter int NUM_BANKS    = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [39:0] s_data_i,
  input  logic [0:0]  s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  output int          pending_o,
  output int          mismatches_o,
  output int          compared_o
);
  import sos_pkg::*;
  import sos_bench_pkg::*;

  logic signed [COEF_W-1:0] coef_mem [NUM_BANKS][MAX_SECTIONS][NUM_SLOTS];
  logic [HIST_W-1:0]        hist_mem [NUM_BANKS][MAX_SECTIONS][2];
  logic [2:0]               band_en;
  logic [3:0]               sect_cnt [CFG_BANKS];
  logic [DATA_W-1:0]        filtered_q [$];
  int                       mismatches = 0;
  int                       compared = 0;

  function automatic logic [HIST_W-1:0] scaled_term(input logic signed [COEF_W-1:0] c,
                                                    input logic signed [HIST_W-1:0] v);
    logic signed [PROD_W-1:0] p;
    p = c * v;
    p = p >>> FRAC_BITS;
    return p[HIST_W-1:0];
  endfunction

  task automatic filter_sample(input logic signed [DATA_W-1:0] pcm,
                               output logic [DATA_W-1:0] filtered);
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [DATA_W-1:0]        sum;
    logic [HIST_W-1:0]        xs, w0, w1, w2, acc;
    int                       n;
    sum = '0;
    for (int b = 0; b < NUM_BANKS && b < CFG_BANKS; b++) begin
      if (band_en[b]) begin
        n = (sect_cnt[b] > MAX_SECTIONS) ? MAX_SECTIONS : int'(sect_cnt[b]);
        x = pcm;
        y = '0;
        for (int s = 0; s < n; s++) begin
          w1 = hist_mem[b][s][0];
          w2 = hist_mem[b][s][1];
          xs = scaled_term(coef_mem[b][s][SLOT_GAIN], {{(HIST_W-DATA_W){x[DATA_W-1]}}, x});
          w0 = xs - scaled_term(coef_mem[b][s][SLOT_A1], w1)
                  - scaled_term(coef_mem[b][s][SLOT_A2], w2);
          acc = scaled_term(coef_mem[b][s][SLOT_B0], w0)
              + scaled_term(coef_mem[b][s][SLOT_B1], w1)
              + scaled_term(coef_mem[b][s][SLOT_B2], w2);
          hist_mem[b][s][1] = w1;
          hist_mem[b][s][0] = w0;
          if ($signed(acc) > 32767) y = SAT_MAX;
          else if ($signed(acc) < -32768) y = SAT_MIN;
          else y = acc[DATA_W-1:0];
          x = y;
        end
        sum = sum + y;
      end
    end
    filtered = sum;
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t             xfer;
    logic [DATA_W-1:0] filtered;
    logic [DATA_W-1:0] want;
    if (!rst_ni) begin
      foreach (hist_mem[b, s, k]) hist_mem[b][s][k] = '0;
      band_en = '0;
      sect_cnt[0] = 4'd7;
      sect_cnt[1] = 4'd8;
      sect_cnt[2] = 4'd7;
      filtered_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BAND_ENABLE:   band_en = cfg_wdata_i[2:0];
          REG_SECTIONS_LOW:  sect_cnt[0] = cfg_wdata_i;
          REG_SECTIONS_BP:   sect_cnt[1] = cfg_wdata_i;
          REG_SECTIONS_HIGH: sect_cnt[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("filtered transfer with nothing expected", m_data_i, 'x);
        end else begin
          want = filtered_q.pop_front();
          compared++;
          if (m_data_i !== want) report_mismatch("filtered", m_data_i, want);
        end
      end
      if (s_valid_i && s_ready_i) begin
        xfer = s_data_i;
        if (s_user_i == FUNC_COEF) begin
          if (xfer.coef_bank < NUM_BANKS && xfer.coef_section < MAX_SECTIONS &&
              xfer.coef_slot < NUM_SLOTS)
            coef_mem[xfer.coef_bank][xfer.coef_section][xfer.coef_slot] = xfer.coef_value;
        end else begin
          filter_sample(xfer.pcm, filtered);
          filtered_q.push_back(filtered);
        end
      end
    end
    pending_o    <= filtered_q.size();
    mismatches_o <= mismatches;
    compared_o   <= compared;
  end

endmodule

### bench/testbench.sv
// Top of the bench: clock, reset, stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import sos_pkg::*;
  import sos_bench_pkg::*;

  localparam int MAX_SECTIONS  = 8;
  localparam int FRAC_BITS     = 14;
  localparam int NUM_BANKS     = 3;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 240;
  localparam int HOLD_CYCLES   = 600;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 112;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [3:0]  cfg_wdata_i = '0;

  int src_idle_pct = 38;
  int sink_idle_pct = 66;
  int hold_tokens = 0;
  int holds_done = 0;
  int samples_sent = 0;
  int coefs_sent = 0;
  int settings_done = 0;
  int quiet_cycles = 0;
  int pending;
  int mismatches;
  int compared;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sos_iir_filter_bank_q14_unit #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .FRAC_BITS   (FRAC_BITS),
    .NUM_BANKS   (NUM_BANKS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  sos_filter_checker #(
    .MAX_SECTIONS(MAX_SECTIONS),
    .FRAC_BITS   (FRAC_BITS),
    .NUM_BANKS   (NUM_BANKS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .mismatches_o(mismatches),
    .compared_o  (compared)
  );

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done < hold_tokens) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t random_item();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[39:0];
  endfunction

  function automatic logic [15:0] stable_coef(input logic [2:0] slot);
    int v;
    case (slot)
      SLOT_A1:   v = int'($urandom_range(0, 40000)) - 20000;
      SLOT_A2:   v = int'($urandom_range(0, 12000));
      SLOT_GAIN: v = int'($urandom_range(6000, 20000));
      default:   v = int'($urandom_range(0, 16384)) - 8192;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [3:0] pick_sections();
    if ($urandom_range(0, 99) < 10)
      return $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  task automatic send_item(input func_e func, input item_t xfer);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= xfer;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FUNC_COEF) coefs_sent++;
    else samples_sent++;
  endtask

  task automatic send_sample(input logic [15:0] pcm);
    item_t xfer;
    xfer = random_item();
    xfer.pcm = pcm;
    send_item(FUNC_FILTER, xfer);
  endtask

  task automatic write_coef(input logic [1:0] bank, input logic [2:0] sect,
                            input logic [2:0] slot, input logic [15:0] value);
    item_t xfer;
    xfer = random_item();
    xfer.coef_bank    = bank;
    xfer.coef_section = sect;
    xfer.coef_slot    = slot;
    xfer.coef_value   = value;
    send_item(FUNC_COEF, xfer);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [3:0] band, input logic [3:0] lo,
                                input logic [3:0] bp, input logic [3:0] hi);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_BAND_ENABLE;
    cfg_wdata_i <= band;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SECTIONS_LOW;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SECTIONS_BP;
    cfg_wdata_i <= bp;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SECTIONS_HIGH;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  initial begin
    logic [2:0] slot;
    logic [1:0] bank;
    int         sent;
    int         pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_settings(4'd7, 4'd8, 4'd8, 4'd8);
    for (int b = 0; b < NUM_BANKS; b++)
      for (int s = 0; s < MAX_SECTIONS; s++)
        for (int k = 0; k < NUM_SLOTS; k++)
          write_coef(2'(b), 3'(s), 3'(k), stable_coef(3'(k)));

    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    write_coef(BANK_NONE, 3'd0, SLOT_GAIN, 16'h7FFF);
    write_coef(BANK_LOW, 3'd0, 3'd6, 16'h8000);
    write_coef(BANK_HIGH, 3'd7, 3'd7, 16'h7FFF);
    send_sample(16'h4000);
    write_coef(BANK_LOW, 3'd0, SLOT_GAIN, 16'h7FFF);
    write_coef(BANK_LOW, 3'd0, SLOT_A1, 16'h8000);
    write_coef(BANK_LOW, 3'd0, SLOT_B0, 16'h7FFF);
    write_coef(BANK_HIGH, 3'd7, SLOT_B2, 16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    apply_settings(4'd7, 4'd0, 4'd15, 4'd1);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h1234);
    apply_settings(4'd0, 4'd8, 4'd8, 4'd8);
    send_sample(16'h7FFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       apply_settings(4'd7, 4'd8, 4'd8, 4'd8);
        1:       apply_settings(4'd0, 4'd1, 4'd1, 4'd1);
        2:       apply_settings(4'd7, 4'd1, 4'd1, 4'd1);
        3:       apply_settings(4'd5, 4'd0, 4'd9, 4'd15);
        default: apply_settings(4'($urandom_range(0, 7)), pick_sections(), pick_sections(),
                                pick_sections());
      endcase
      case (phase / 4)
        0: begin
          src_idle_pct  = 38;
          sink_idle_pct = 66;
        end
        1: begin
          src_idle_pct  = 66;
          sink_idle_pct = 38;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent == 40 && (phase == 2 || phase == 9) && hold_tokens == holds_done)
          hold_tokens <= hold_tokens + 1;
        if (sent == 60 && (phase == 6 || phase == 10)) wait_results_drained();
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_sample(16'($urandom()));
            6, 7:             send_sample(16'(int'($urandom_range(0, 4000)) - 2000));
            8:                send_sample(16'h7FFF);
            default:          send_sample(16'h8000);
          endcase
          sent++;
        end else if (pick < 92) begin
          slot = 3'($urandom_range(0, 5));
          write_coef(2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)), slot,
                     stable_coef(slot));
          sent++;
        end else if (pick < 96) begin
          write_coef(2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)),
                     3'($urandom_range(0, 5)), 16'($urandom()));
          sent++;
        end else if ($urandom_range(0, 1) == 0) begin
          write_coef(BANK_NONE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     16'($urandom()));
        end else begin
          bank = 2'($urandom_range(0, 3));
          write_coef(bank, 3'($urandom_range(0, 7)), 3'($urandom_range(6, 7)),
                     16'($urandom()));
        end
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples and %0d coefficient words under %0d register settings,",
             samples_sent, coefs_sent, settings_done);
    $display("across three idle mixes and long output holds; %0d results compared.",
             compared);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
